/* design/bpfa_pkg.sv */
// Package for the bitmap page frame allocator: sizes, field widths, codes
// and the reset image of the usage bitmap. No dependencies.
`timescale 1ns / 1ps

package bpfa_pkg;

  // Map geometry
  localparam int MAP_WORDS   = 1024;
  localparam int BLOCK_BYTES = 4096;
  localparam int WORD_BITS   = 32;
  localparam int MAP_BITS    = MAP_WORDS * WORD_BITS;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int WORD_AW     = $clog2(MAP_WORDS);
  localparam int BIT_AW      = $clog2(WORD_BITS);
  localparam int BLKN_W      = WORD_AW + BIT_AW;

  // Field widths
  localparam int ADDR_W   = 27;
  localparam int CFG_W    = 16;
  localparam int COUNT_W  = 16;
  localparam int STATUS_W = 2;
  localparam int AB_W     = ADDR_W - BLOCK_SHIFT;

  // Compare width wide enough for block numbers, limits and word offsets
  localparam int BIG_A = (AB_W > CFG_W) ? AB_W : CFG_W;
  localparam int BIG_W = (BIG_A > BLKN_W + 1) ? BIG_A : BLKN_W + 1;

  // Reserved low memory (first 1 MB) and reset values
  localparam int RESERVED_BLOCKS = (1024 * 1024) / BLOCK_BYTES;
  localparam int RESV_BITS = (RESERVED_BLOCKS < MAP_BITS) ? RESERVED_BLOCKS : MAP_BITS;
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;
  localparam int RESV_CNT  = (RESV_BITS > COUNT_MAX) ? COUNT_MAX : RESV_BITS;
  localparam int CFG_RESET = 32768;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_OOM      = 2'd1,
    STAT_BAD_FREE = 2'd2
  } status_t;

  // Reset content of one bitmap word: reserved bits set, others clear
  function automatic logic [WORD_BITS-1:0] init_word(input logic [31:0] idx);
    logic [31:0] lo;
    lo = idx << BIT_AW;
    if (lo + 32'(WORD_BITS) <= 32'(RESV_BITS)) begin
      return '1;
    end else if (lo >= 32'(RESV_BITS)) begin
      return '0;
    end else begin
      return WORD_BITS'((32'h1 << (32'(RESV_BITS) - lo)) - 32'h1);
    end
  endfunction

endpackage

/* design/bpfa_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on bpfa_pkg for field widths and codes.
`timescale 1ns / 1ps

interface bpfa_in_if import bpfa_pkg::*; ();
  logic              valid;
  logic              ready;
  mode_t             mode;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output mode, output address, input ready);
  modport sink   (input valid, input mode, input address, output ready);
endinterface

interface bpfa_out_if import bpfa_pkg::*; ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic [ADDR_W-1:0]  block_address;
  logic [COUNT_W-1:0] used_count;

  modport source (output valid, output status, output block_address, output used_count,
                  input ready);
  modport sink   (input valid, input status, input block_address, input used_count,
                  output ready);
endinterface

/* design/bitmap_page_frame_allocator.sv */
// Top level of the bitmap page frame allocator: usage bitmap RAM, scan and
// free sequencer, output register. Depends on bpfa_pkg and bpfa_if.
`timescale 1ns / 1ps
//
// Usage:
//   in_chan  : requests. mode = alloc takes the lowest free block below the
//              limit; mode = free releases the block holding address.
//   out_chan : one result per request: status, block byte address (zero
//              unless an alloc succeeded) and the used-block count after it.
//   cfg_we / cfg_wdata : managed block count, written while idle.
// One request is handled at a time; in_chan.ready is high only while idle.
// The bitmap lives in a 1024 x 32 RAM with a registered read port. An alloc
// streams one word per cycle through the RAM read port; it ends at the first
// word under the limit that holds a free block, or gives an out-of-memory
// result once every word under the limit is read (without reading any word
// when the limit is zero).
// A free reads the word on acceptance, checks and writes it back, then loads
// the output; a block past the limit goes straight to the output load.
// After reset a clearing pass writes the reset image into all 1024 words,
// one per cycle, before the first request is taken; cfg writes are taken
// during it. The output register holds a result until out_chan.ready; the
// next request is accepted meanwhile and waits in its final state if the
// output is still full when it finishes.

module bitmap_page_frame_allocator import bpfa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  bpfa_in_if.sink            in_chan,
  bpfa_out_if.source         out_chan,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FREE  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [WORD_AW-1:0]   clr_w_r, clr_w_nxt;
  logic [CFG_W-1:0]     managed_r;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [WORD_AW:0]     rd_w_r, rd_w_nxt;
  logic [WORD_AW-1:0]   chk_w_r, chk_w_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [BLKN_W-1:0]    fblk_r, fblk_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]    res_addr_r, res_addr_nxt;
  logic [COUNT_W-1:0]   res_cnt_r, res_cnt_nxt;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [ADDR_W-1:0]    out_addr_r;
  logic [COUNT_W-1:0]   out_cnt_r;
  logic                 out_load;

  // Bitmap RAM
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 mem_we, mem_re;
  logic [WORD_AW-1:0]   mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= map_mem[mem_raddr];
    end
  end

  // Effective limit and derived compares
  logic [BIG_W-1:0]     limit;
  logic [BIG_W-1:0]     ablk_big;
  logic [AB_W-1:0]      ablk;
  logic                 rd_in_range;
  logic [BIG_W-1:0]     rem;
  logic [WORD_BITS-1:0] lim_mask, avail;
  logic [BIT_AW-1:0]    free_idx;
  logic                 found;
  logic [BLKN_W-1:0]    found_blk;
  logic [BIT_AW-1:0]    fbit;

  assign limit = (BIG_W'(managed_r) > BIG_W'(MAP_BITS)) ? BIG_W'(MAP_BITS)
                                                        : BIG_W'(managed_r);
  assign ablk     = in_chan.address[ADDR_W-1:BLOCK_SHIFT];
  assign ablk_big = BIG_W'(ablk);

  assign rd_in_range = (rd_w_r < (WORD_AW+1)'(MAP_WORDS)) &&
                       (BIG_W'({rd_w_r, {BIT_AW{1'b0}}}) < limit);

  // Bits of the checked word that lie below the limit
  assign rem      = limit - BIG_W'({chk_w_r, {BIT_AW{1'b0}}});
  assign lim_mask = (rem >= BIG_W'(WORD_BITS)) ? '1
                  : ((WORD_BITS'(1) << rem[BIT_AW-1:0]) - WORD_BITS'(1));
  assign avail    = ~rdata_r & lim_mask;
  assign found    = |avail;
  assign found_blk = {chk_w_r, free_idx};
  assign fbit     = fblk_r[BIT_AW-1:0];

  // Lowest free bit
  always_comb begin
    free_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        free_idx = BIT_AW'(b);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_w_nxt      = clr_w_r;
    count_nxt      = count_r;
    rd_w_nxt       = rd_w_r;
    chk_w_nxt      = chk_w_r;
    chk_vld_nxt    = 1'b0;
    fblk_nxt       = fblk_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_cnt_nxt    = res_cnt_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    out_load       = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_w_r;
        mem_wdata = init_word(32'(clr_w_r));
        if (clr_w_r == WORD_AW'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_w_nxt = clr_w_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_chan.valid) begin
          if (in_chan.mode == MODE_ALLOC) begin
            rd_w_nxt  = '0;
            state_nxt = S_SCAN;
          end else if (ablk_big >= limit) begin
            res_status_nxt = STAT_BAD_FREE;
            res_addr_nxt   = '0;
            res_cnt_nxt    = count_r;
            state_nxt      = S_DONE;
          end else begin
            fblk_nxt  = BLKN_W'(ablk);
            mem_re    = 1'b1;
            mem_raddr = fblk_nxt[BLKN_W-1:BIT_AW];
            state_nxt = S_FREE;
          end
        end
      end
      S_SCAN: begin
        if (chk_vld_r && found) begin
          // Claim the block and write the word back
          mem_we         = 1'b1;
          mem_waddr      = chk_w_r;
          mem_wdata      = rdata_r | (WORD_BITS'(1) << free_idx);
          count_nxt      = (count_r == '1) ? count_r : count_r + 1'b1;
          res_status_nxt = STAT_OK;
          res_addr_nxt   = ADDR_W'({found_blk, {BLOCK_SHIFT{1'b0}}});
          res_cnt_nxt    = count_nxt;
          state_nxt      = S_DONE;
        end else if (!chk_vld_r && !rd_in_range) begin
          res_status_nxt = STAT_OOM;
          res_addr_nxt   = '0;
          res_cnt_nxt    = count_r;
          state_nxt      = S_DONE;
        end else if (rd_in_range) begin
          mem_re      = 1'b1;
          mem_raddr   = rd_w_r[WORD_AW-1:0];
          chk_vld_nxt = 1'b1;
          chk_w_nxt   = rd_w_r[WORD_AW-1:0];
          rd_w_nxt    = rd_w_r + 1'b1;
        end
      end
      S_FREE: begin
        res_addr_nxt = '0;
        if (rdata_r[fbit]) begin
          mem_we         = 1'b1;
          mem_waddr      = fblk_r[BLKN_W-1:BIT_AW];
          mem_wdata      = rdata_r & ~(WORD_BITS'(1) << fbit);
          count_nxt      = (count_r == '0) ? count_r : count_r - 1'b1;
          res_status_nxt = STAT_OK;
        end else begin
          res_status_nxt = STAT_BAD_FREE;
        end
        res_cnt_nxt = count_nxt;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_w_r     <= '0;
      count_r     <= COUNT_W'(RESV_CNT);
      managed_r   <= CFG_W'(CFG_RESET);
      rd_w_r      <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_w_r   <= clr_w_nxt;
      count_r   <= count_nxt;
      rd_w_r    <= rd_w_nxt;
      chk_vld_r <= chk_vld_nxt;
      if (cfg_we) begin
        managed_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    chk_w_r      <= chk_w_nxt;
    fblk_r       <= fblk_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_cnt_r    <= res_cnt_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_cnt_r    <= res_cnt_r;
    end
  end

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.block_address = out_addr_r;
  assign out_chan.used_count    = out_cnt_r;

  // Checks
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(MAP_BITS))
    else $error("used count exceeds map size");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !mem_we)
    else $error("bitmap write outside of a request");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result shown without a finished request");

  a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && res_status_r != STAT_OK |-> res_addr_r == '0)
    else $error("nonzero block address on a failed request");

  a_scan_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN && chk_vld_r |-> BIG_W'({chk_w_r, {BIT_AW{1'b0}}}) < limit)
    else $error("scan checked a word past the limit");

endmodule
